>>> rtl/odo_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odo_pkg - shared types and constants for the wheel odometry block
// Word types, job entry, sequencer states, fixed-point widths and the
// CORDIC arctangent table.
// ----------------------------------------------------------------------------
package odo_pkg;

  localparam int DEF_CORDIC_STEPS = 24;
  localparam int DEF_COUNT_BITS   = 32;
  localparam int QUEUE_DEPTH      = 2;

  localparam int CFG_INDEX_BITS = 8;
  localparam logic [CFG_INDEX_BITS-1:0] REG_DISTANCE_PER_COUNT = 8'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INV_TRACK_WIDTH    = 8'd1;
  localparam logic [31:0] RESET_DISTANCE_PER_COUNT = 32'd533830;
  localparam logic [23:0] RESET_INV_TRACK_WIDTH    = 24'd163840;

  localparam int TRAVEL_W = 58;   // wheel travel, 2^-24 m, signed
  localparam int NUM_W    = 71;   // |travel| * 15625
  localparam int DEN_W    = 26;   // 4 * elapsed_us
  localparam int LIN_QW   = 32;
  localparam int ANG_QW   = 48;

  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
  localparam logic [21:0] RAD_TO_BAM = 22'd2670177;

  typedef struct packed {
    logic signed [31:0] left_count;
    logic signed [31:0] right_count;
    logic [23:0]        elapsed_us;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic [31:0]        heading_angle;
    logic signed [31:0] linear_speed;
    logic signed [31:0] angular_speed;
    logic               speed_valid;
  } out_word_t;

  typedef struct packed {
    logic signed [31:0] dl;
    logic signed [31:0] dr;
    logic [23:0]        dt;
  } job_t;

  typedef struct packed {
    logic push;
    logic pop;
  } queue_ctl_t;

  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

  typedef enum logic [4:0] {
    B_IDLE, B_TL, B_TR, B_CE, B_SCALE,
    B_H0, B_H1, B_H2, B_H3, B_H4, B_WAITC,
    B_X0, B_X1, B_X2, B_X3, B_X4, B_WAITD,
    B_A0, B_A1, B_A2, B_DONE
  } back_state_t;

  function automatic logic [31:0] atan_bam(input logic [4:0] i);
    logic [31:0] r;
    case (i)
      5'd0:  r = 32'd536870912;
      5'd1:  r = 32'd316933406;
      5'd2:  r = 32'd167458907;
      5'd3:  r = 32'd85004756;
      5'd4:  r = 32'd42667331;
      5'd5:  r = 32'd21354465;
      5'd6:  r = 32'd10679838;
      5'd7:  r = 32'd5340245;
      5'd8:  r = 32'd2670163;
      5'd9:  r = 32'd1335087;
      5'd10: r = 32'd667544;
      5'd11: r = 32'd333772;
      5'd12: r = 32'd166886;
      5'd13: r = 32'd83443;
      5'd14: r = 32'd41722;
      5'd15: r = 32'd20861;
      5'd16: r = 32'd10430;
      5'd17: r = 32'd5215;
      5'd18: r = 32'd2608;
      5'd19: r = 32'd1304;
      5'd20: r = 32'd652;
      5'd21: r = 32'd326;
      5'd22: r = 32'd163;
      5'd23: r = 32'd81;
      5'd24: r = 32'd41;
      5'd25: r = 32'd20;
      5'd26: r = 32'd10;
      5'd27: r = 32'd5;
      5'd28: r = 32'd3;
      5'd29: r = 32'd1;
      5'd30: r = 32'd1;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/diff_drive_odometry_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// diff_drive_odometry_unit - differential drive wheel odometry
// Integrates encoder samples into position, heading and wheel speeds.
// ----------------------------------------------------------------------------
// Each input word carries absolute left/right encoder counts and the time
// since the last sample; each produces one output word with Q15.16 position,
// a binary-angle heading (full turn = 2^32) and saturated Q15.16 linear and
// yaw speeds, flagged invalid when the elapsed time is zero. The time a sample
// takes from queue to output is bound by the 48-step serial
// divider for the yaw rate (the CORDIC runs alongside it); samples are
// processed one at a time. A two-word queue sits in front of the sequencer,
// so the input keeps accepting while a result waits on a stalled output.
// Write distance_per_count (index 0) and inv_track_width (index 1) only while
// no sample is in flight; writes to other indices are dropped.
// ----------------------------------------------------------------------------
module diff_drive_odometry_unit #(
  parameter int CORDIC_STEPS = odo_pkg::DEF_CORDIC_STEPS,
  parameter int COUNT_BITS   = odo_pkg::DEF_COUNT_BITS
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  input  wire logic                               in_valid,
  output logic                                    in_stall,
  input  wire odo_pkg::in_word_t                  in_word,
  output logic                                    out_valid,
  input  wire logic                               out_stall,
  output odo_pkg::out_word_t                      out_word,
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [odo_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [31:0]                        cfg_data
);

  logic [31:0] distance_per_count;
  logic [23:0] inv_track_width;

  odo_pkg::queue_ctl_t  q_ctl;
  odo_pkg::queue_stat_t q_stat;
  odo_pkg::job_t        wr_job;
  odo_pkg::job_t        rd_job;

  // register writes are always accepted
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      distance_per_count <= odo_pkg::RESET_DISTANCE_PER_COUNT;
      inv_track_width    <= odo_pkg::RESET_INV_TRACK_WIDTH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        odo_pkg::REG_DISTANCE_PER_COUNT: distance_per_count <= cfg_data;
        odo_pkg::REG_INV_TRACK_WIDTH:    inv_track_width    <= cfg_data[23:0];
        default: begin
        end
      endcase
    end
  end

  // intake: count differences against the previous sample
  odo_front #(.COUNT_BITS(COUNT_BITS)) u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_stat.full),
    .q_push   (q_ctl.push),
    .q_job    (wr_job)
  );

  // decouple intake from the sequencer
  odo_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .ctl    (q_ctl),
    .wr_job (wr_job),
    .rd_job (rd_job),
    .stat   (q_stat)
  );

  // arithmetic sequencer and output register
  odo_back #(.CORDIC_STEPS(CORDIC_STEPS)) u_back (
    .clk       (clk),
    .rst       (rst),
    .job       (rd_job),
    .q_empty   (q_stat.empty),
    .q_pop     (q_ctl.pop),
    .dpc       (distance_per_count),
    .itw       (inv_track_width),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule
`default_nettype wire

>>> rtl/odo_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odo_front - sample intake
// Accept encoder words, form count differences and push jobs to the queue.
// ----------------------------------------------------------------------------
module odo_front #(
  parameter int COUNT_BITS = odo_pkg::DEF_COUNT_BITS
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire odo_pkg::in_word_t in_word,
  input  wire logic             q_full,
  output logic                  q_push,
  output odo_pkg::job_t         q_job
);

  localparam int SH = 32 - COUNT_BITS;

  logic [31:0] prev_left;
  logic [31:0] prev_right;
  logic [31:0] raw_l;
  logic [31:0] raw_r;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;

  // keep the low COUNT_BITS of the difference, read as signed
  assign raw_l = in_word.left_count - prev_left;
  assign raw_r = in_word.right_count - prev_right;
  assign q_job.dl = $signed(raw_l << SH) >>> SH;
  assign q_job.dr = $signed(raw_r << SH) >>> SH;
  assign q_job.dt = in_word.elapsed_us;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_left  <= '0;
      prev_right <= '0;
    end else if (q_push) begin
      prev_left  <= in_word.left_count;
      prev_right <= in_word.right_count;
    end
  end

endmodule
`default_nettype wire

>>> rtl/odo_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odo_queue - job queue
// Short FIFO between intake and the arithmetic sequencer.
// ----------------------------------------------------------------------------
module odo_queue (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire odo_pkg::queue_ctl_t ctl,
  input  wire odo_pkg::job_t       wr_job,
  output odo_pkg::job_t            rd_job,
  output odo_pkg::queue_stat_t     stat
);

  localparam int DEPTH = odo_pkg::QUEUE_DEPTH;
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  odo_pkg::job_t slots [DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [CW-1:0] count;

  assign rd_job     = slots[rptr];
  assign stat.empty = (count == '0);
  assign stat.full  = (count == CW'(DEPTH));

  always_ff @(posedge clk) begin
    if (ctl.push) begin
      slots[wptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (ctl.push) begin
        wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (ctl.pop) begin
        rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (ctl.push && !ctl.pop) begin
        count <= count + 1'b1;
      end else if (!ctl.push && ctl.pop) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

>>> rtl/odo_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odo_div - serial restoring divider
// One quotient bit per cycle; flags a quotient that needs more than QW bits.
// ----------------------------------------------------------------------------
module odo_div #(
  parameter int NW = 71,
  parameter int DW = 26,
  parameter int QW = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [NW-1:0] num,
  input  wire logic [DW-1:0] den,
  output logic               busy,
  output logic [QW-1:0]      quo,
  output logic               ovf
);

  localparam int CW = $clog2(QW + 1);

  logic [DW-1:0] rem;
  logic [QW-1:0] low;
  logic [CW-1:0] cnt;
  logic [DW:0]   trial;
  logic          ge;

  assign trial = {rem, low[QW-1]};
  assign ge    = trial >= {1'b0, den};

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= DW'(num >> QW);
      low <= num[QW-1:0];
      ovf <= (num >> QW) >= NW'(den);
      cnt <= '0;
    end else if (busy) begin
      rem <= ge ? DW'(trial - {1'b0, den}) : trial[DW-1:0];
      low <= low << 1;
      quo <= {quo[QW-2:0], ge};
      cnt <= cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
    end else if (busy && cnt == CW'(QW - 1)) begin
      busy <= 1'b0;
    end
  end

endmodule
`default_nettype wire

>>> rtl/odo_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// odo_back - odometry sequencer
// Travel, CORDIC, position and heading update, speed division and output.
// ----------------------------------------------------------------------------
module odo_back #(
  parameter int CORDIC_STEPS = odo_pkg::DEF_CORDIC_STEPS
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire odo_pkg::job_t  job,
  input  wire logic           q_empty,
  output logic                q_pop,
  input  wire logic [31:0]    dpc,
  input  wire logic [23:0]    itw,
  output logic                out_valid,
  input  wire logic           out_stall,
  output odo_pkg::out_word_t  out_word
);

  localparam int TW = odo_pkg::TRAVEL_W;
  localparam int NW = odo_pkg::NUM_W;
  localparam int SW = $clog2(CORDIC_STEPS + 1);

  odo_pkg::back_state_t state, state_next;

  // job
  logic signed [31:0] dl, dr;
  logic [23:0]        dt;

  // shared multiplier
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic signed [65:0] p;

  logic signed [TW-1:0] tl, tr, c, e;
  logic signed [TW:0]   tsum;
  logic [TW-1:0]        c_mag, e_mag;
  logic [NW-1:0]        nc, ne, mc, me;

  logic [55:0] hq;
  logic [31:0] ph, hlo, dth;
  logic signed [33:0] xt;
  logic signed [65:0] xsum;
  logic [31:0] dx, dy;
  logic [55:0] am;
  logic [71:0] atot;
  logic [55:0] av;

  // CORDIC
  logic signed [33:0] cx, cy, cz, xs, ys;
  logic [33:0]        at;
  logic               cflip, cbusy;
  logic [SW-1:0]      ccnt;
  logic [4:0]         csh;
  logic signed [33:0] cs_full, sn_full;

  // dividers
  logic              div_start;
  logic              lbusy, abusy, lovf, aovf;
  logic [odo_pkg::LIN_QW-1:0] lq;
  logic [odo_pkg::ANG_QW-1:0] aq;

  // accumulators
  logic [31:0] x_acc, y_acc, heading_acc;

  logic        load_out;
  logic [31:0] lin, ang;
  logic        a_big;

  assign mul_p = mul_a * mul_b;

  // next state and control
  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    div_start  = 1'b0;
    load_out   = 1'b0;
    case (state)
      odo_pkg::B_IDLE: begin
        if (!q_empty) begin
          q_pop      = 1'b1;
          state_next = odo_pkg::B_TL;
        end
      end
      odo_pkg::B_TL:    state_next = odo_pkg::B_TR;
      odo_pkg::B_TR:    state_next = odo_pkg::B_CE;
      odo_pkg::B_CE:    state_next = odo_pkg::B_SCALE;
      odo_pkg::B_SCALE: state_next = odo_pkg::B_H0;
      odo_pkg::B_H0: begin
        div_start  = 1'b1;
        state_next = odo_pkg::B_H1;
      end
      odo_pkg::B_H1: state_next = odo_pkg::B_H2;
      odo_pkg::B_H2: state_next = odo_pkg::B_H3;
      odo_pkg::B_H3: state_next = odo_pkg::B_H4;
      odo_pkg::B_H4: state_next = odo_pkg::B_WAITC;
      odo_pkg::B_WAITC: begin
        if (!cbusy) begin
          state_next = odo_pkg::B_X0;
        end
      end
      odo_pkg::B_X0: state_next = odo_pkg::B_X1;
      odo_pkg::B_X1: state_next = odo_pkg::B_X2;
      odo_pkg::B_X2: state_next = odo_pkg::B_X3;
      odo_pkg::B_X3: state_next = odo_pkg::B_X4;
      odo_pkg::B_X4: state_next = odo_pkg::B_WAITD;
      odo_pkg::B_WAITD: begin
        if (!lbusy && !abusy) begin
          state_next = odo_pkg::B_A0;
        end
      end
      odo_pkg::B_A0: state_next = odo_pkg::B_A1;
      odo_pkg::B_A1: state_next = odo_pkg::B_A2;
      odo_pkg::B_A2: state_next = odo_pkg::B_DONE;
      odo_pkg::B_DONE: begin
        if (!out_valid || !out_stall) begin
          load_out   = 1'b1;
          state_next = odo_pkg::B_IDLE;
        end
      end
      default: state_next = odo_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= odo_pkg::B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      odo_pkg::B_TL: begin
        mul_a = 33'(dl);
        mul_b = {1'b0, dpc};
      end
      odo_pkg::B_TR: begin
        mul_a = 33'(dr);
        mul_b = {1'b0, dpc};
      end
      odo_pkg::B_H0: begin
        mul_a = {1'b0, e[31:0]};
        mul_b = {9'b0, itw};
      end
      odo_pkg::B_H1: begin
        mul_a = 33'($signed(e[TW-1:32]));
        mul_b = {9'b0, itw};
      end
      odo_pkg::B_H2: begin
        mul_a = {1'b0, hq[31:0]};
        mul_b = {11'b0, odo_pkg::RAD_TO_BAM};
      end
      odo_pkg::B_H3: begin
        mul_a = {1'b0, ph};
        mul_b = {11'b0, odo_pkg::RAD_TO_BAM};
      end
      odo_pkg::B_X0: begin
        mul_a = {1'b0, c[31:0]};
        mul_b = cs_full[32:0];
      end
      odo_pkg::B_X1: begin
        mul_a = 33'($signed(c[TW-1:32]));
        mul_b = cs_full[32:0];
      end
      odo_pkg::B_X2: begin
        mul_a = {1'b0, c[31:0]};
        mul_b = sn_full[32:0];
      end
      odo_pkg::B_X3: begin
        mul_a = 33'($signed(c[TW-1:32]));
        mul_b = sn_full[32:0];
      end
      odo_pkg::B_A0: begin
        mul_a = {1'b0, aq[31:0]};
        mul_b = {9'b0, itw};
      end
      odo_pkg::B_A1: begin
        mul_a = {17'b0, aq[47:32]};
        mul_b = {9'b0, itw};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign tr    = p[65:8];
  assign tsum  = {tl[TW-1], tl} + {tr[TW-1], tr};
  assign c_mag = c[TW-1] ? TW'(-c) : TW'(c);
  assign e_mag = e[TW-1] ? TW'(-e) : TW'(e);
  assign mc    = NW'(c_mag);
  assign me    = NW'(e_mag);
  assign xsum  = p + 66'(xt);
  assign atot  = {p[39:0], 32'b0} + 72'(am);

  // datapath
  always_ff @(posedge clk) begin
    if (q_pop) begin
      dl <= job.dl;
      dr <= job.dr;
      dt <= job.dt;
    end
    case (state)
      odo_pkg::B_TL: p <= mul_p;
      odo_pkg::B_TR: begin
        p  <= mul_p;
        tl <= p[65:8];
      end
      odo_pkg::B_CE: begin
        c <= tsum[TW:1];
        e <= tr - tl;
      end
      odo_pkg::B_SCALE: begin
        // times 15625 = 2^14 - 2^9 - 2^8 + 2^3 + 1
        nc <= (mc << 14) - (mc << 9) - (mc << 8) + (mc << 3) + mc;
        ne <= (me << 14) - (me << 9) - (me << 8) + (me << 3) + me;
      end
      odo_pkg::B_H0: p <= mul_p;
      odo_pkg::B_H1: begin
        p  <= mul_p;
        hq <= p[55:0];
      end
      odo_pkg::B_H2: begin
        p  <= mul_p;
        ph <= 32'(hq[55:32]) + p[31:0];
      end
      odo_pkg::B_H3: begin
        p   <= mul_p;
        hlo <= p[63:32];
      end
      odo_pkg::B_H4: dth <= p[31:0] + hlo;
      odo_pkg::B_X0: p <= mul_p;
      odo_pkg::B_X1: begin
        p  <= mul_p;
        xt <= p[65:32];
      end
      odo_pkg::B_X2: begin
        p  <= mul_p;
        dx <= xsum[37:6];
      end
      odo_pkg::B_X3: begin
        p  <= mul_p;
        xt <= p[65:32];
      end
      odo_pkg::B_X4: dy <= xsum[37:6];
      odo_pkg::B_A0: p <= mul_p;
      odo_pkg::B_A1: begin
        p  <= mul_p;
        am <= p[55:0];
      end
      odo_pkg::B_A2: av <= atot[71:16];
      default: begin
      end
    endcase
  end

  // CORDIC on the heading held before this step
  assign csh     = 5'(ccnt);
  assign xs      = cx >>> csh;
  assign ys      = cy >>> csh;
  assign at      = {2'b00, odo_pkg::atan_bam(csh)};
  assign cs_full = cflip ? -cx : cx;
  assign sn_full = cflip ? -cy : cy;

  always_ff @(posedge clk) begin
    if (state == odo_pkg::B_TL) begin
      cflip <= heading_acc[31] ^ heading_acc[30];
      cx    <= odo_pkg::CORDIC_GAIN;
      cy    <= '0;
      // fold the left half plane onto the right by a half turn
      cz    <= 34'($signed({heading_acc[31] ^ (heading_acc[31] ^ heading_acc[30]),
                            heading_acc[30:0]}));
      ccnt  <= '0;
    end else if (cbusy) begin
      if (!cz[33]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - $signed(at);
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + $signed(at);
      end
      ccnt <= ccnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cbusy <= 1'b0;
    end else if (state == odo_pkg::B_TL) begin
      cbusy <= 1'b1;
    end else if (cbusy && ccnt == SW'(CORDIC_STEPS - 1)) begin
      cbusy <= 1'b0;
    end
  end

  odo_div #(.NW(NW), .DW(odo_pkg::DEN_W), .QW(odo_pkg::LIN_QW)) u_lin_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (nc),
    .den   ({dt, 2'b00}),
    .busy  (lbusy),
    .quo   (lq),
    .ovf   (lovf)
  );

  odo_div #(.NW(NW), .DW(odo_pkg::DEN_W), .QW(odo_pkg::ANG_QW)) u_ang_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (ne),
    .den   ({dt, 2'b00}),
    .busy  (abusy),
    .quo   (aq),
    .ovf   (aovf)
  );

  // saturate speeds
  always_comb begin
    if (c[TW-1]) begin
      lin = (lovf || lq > 32'h8000_0000) ? 32'h8000_0000 : 32'(-lq);
    end else begin
      lin = (lovf || lq[31]) ? 32'h7fff_ffff : lq;
    end
    if (e[TW-1]) begin
      a_big = (aovf && itw != '0) || av > 56'h8000_0000;
      ang   = a_big ? 32'h8000_0000 : 32'(-av[31:0]);
    end else begin
      a_big = (aovf && itw != '0) || av > 56'h7fff_ffff;
      ang   = a_big ? 32'h7fff_ffff : av[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_word.pos_x         <= x_acc + dx;
      out_word.pos_y         <= y_acc + dy;
      out_word.heading_angle <= heading_acc + dth;
      out_word.linear_speed  <= (dt != '0) ? lin : '0;
      out_word.angular_speed <= (dt != '0) ? ang : '0;
      out_word.speed_valid   <= (dt != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_acc       <= '0;
      y_acc       <= '0;
      heading_acc <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (load_out) begin
        x_acc       <= x_acc + dx;
        y_acc       <= y_acc + dy;
        heading_acc <= heading_acc + dth;
        out_valid   <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench - self-checking bench for diff_drive_odometry_unit
// Random and directed encoder samples go in under random gaps and output
// stalls. An internal odometry predictor computes each expected result, and
// every output word is checked field by field in arrival order.
// ----------------------------------------------------------------------------
module testbench;

  localparam int N_RANDOM = 1500;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  odo_pkg::in_word_t in_word = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  odo_pkg::out_word_t out_word;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [odo_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  diff_drive_odometry_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
    .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #10 clk = ~clk;

  // Predictor state: a private copy of the odometry registers.
  logic [31:0] mdl_dpc;
  logic [23:0] mdl_itw;
  logic [31:0] mdl_prev_l, mdl_prev_r, mdl_x, mdl_y, mdl_hdg;

  odo_pkg::in_word_t  pending_words[$];
  odo_pkg::out_word_t odo_expected[$];
  int        n_errors = 0;
  int        hold_left = 0;   // long receiver hold-off, counted by the monitor
  bit        drain_mode = 1'b0;

  function automatic logic [31:0] atan_tbl(int i);
    logic [31:0] t [32] = '{536870912, 316933406, 167458907, 85004756, 42667331,
      21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
      83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81, 41, 20,
      10, 5, 3, 1, 1, 0};
    return t[i];
  endfunction

  // Wheel travel in 2^-24 m, rounded toward minus infinity.
  function automatic logic signed [63:0] wheel_travel(logic [31:0] now, logic [31:0] was);
    logic signed [31:0] d;
    logic [63:0] m;
    d = now - was;
    m = (d < 0 ? 64'(-64'(d)) : 64'(d)) * 64'(mdl_dpc);
    if (d < 0) return -$signed((m + 64'd255) >> 8);
    return $signed(m >> 8);
  endfunction

  // floor(c * k / 2^38) taken modulo 2^32
  function automatic logic [31:0] step_scale(logic signed [63:0] c, logic signed [63:0] k);
    logic signed [127:0] p;
    p = 128'(c) * 128'(k);
    return 32'(p >>> 38);
  endfunction

  // Saturate a rate magnitude, such as |v| * 15625 / (4 dt), with the sign applied
  function automatic logic [31:0] saturate_rate(logic [127:0] m, bit neg);
    if (neg) return (m > 128'h8000_0000) ? 32'h8000_0000 : 32'(-m);
    return (m > 128'h7fff_ffff) ? 32'h7fff_ffff : 32'(m);
  endfunction

  function automatic odo_pkg::out_word_t odo_predict(odo_pkg::in_word_t w);
    logic signed [63:0] tl, tr, c, e, cx, sy, zx, zy, z, xs, ys;
    logic [31:0] a;
    logic [127:0] mc, me, den;
    logic [63:0] prod;
    bit flip;
    odo_pkg::out_word_t r;
    tl = wheel_travel(w.left_count, mdl_prev_l);
    tr = wheel_travel(w.right_count, mdl_prev_r);
    c = (tl + tr) >>> 1;
    e = tr - tl;
    // CORDIC on the old heading, folded into the right half-plane
    a = mdl_hdg;
    flip = (a >= 32'h4000_0000 && a < 32'hC000_0000);
    if (flip) a = a - 32'h8000_0000;
    z = 64'($signed(a));
    zx = 64'sd652032874;
    zy = 0;
    for (int i = 0; i < odo_pkg::DEF_CORDIC_STEPS; i++) begin
      xs = zx >>> i;
      ys = zy >>> i;
      if (z >= 0) begin
        zx -= ys; zy += xs; z -= 64'(atan_tbl(i));
      end else begin
        zx += ys; zy -= xs; z += 64'(atan_tbl(i));
      end
    end
    cx = flip ? -zx : zx;
    sy = flip ? -zy : zy;
    mdl_x += step_scale(c, cx);
    mdl_y += step_scale(c, sy);
    prod = 64'(e) * 64'(mdl_itw);
    mdl_hdg += 32'((128'(prod) * 128'd2670177) >> 32);
    mdl_prev_l = w.left_count;
    mdl_prev_r = w.right_count;
    r = '0;
    r.pos_x = mdl_x;
    r.pos_y = mdl_y;
    r.heading_angle = mdl_hdg;
    if (w.elapsed_us != 0) begin
      den = 128'(w.elapsed_us) * 4;
      mc = (128'(c < 0 ? -c : c) * 15625) / den;
      me = (128'(e < 0 ? -e : e) * 15625) / den;
      me = (me * 128'(mdl_itw)) >> 16;
      r.linear_speed = saturate_rate(mc, c < 0);
      r.angular_speed = saturate_rate(me, e < 0);
      r.speed_valid = 1'b1;
    end
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 93) return $urandom_range(3, 1);
    return $urandom_range(150, 20);
  endfunction

  // Driver: offer queued words, with random gaps between them.
  int gap_cnt = 0;
  int next_gap = 0;
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        odo_expected.push_back(odo_predict(in_word));
        next_gap = gap_len();
        gap_cnt <= next_gap;
        if (next_gap == 0 && pending_words.size() > 0) begin
          in_word <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end else if (!in_valid) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
        end else if (pending_words.size() > 0) begin
          in_word <= pending_words.pop_front();
          in_valid <= 1'b1;
        end
      end
    end
  end

  // Monitor: check each accepted output word, then pick the next stall.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (odo_expected.size() == 0) begin
          $error("output word with nothing expected");
          n_errors++;
        end else begin
          odo_pkg::out_word_t x;
          x = odo_expected.pop_front();
          if (out_word.pos_x !== x.pos_x) begin
            $error("pos_x exp %h got %h", x.pos_x, out_word.pos_x); n_errors++;
          end
          if (out_word.pos_y !== x.pos_y) begin
            $error("pos_y exp %h got %h", x.pos_y, out_word.pos_y); n_errors++;
          end
          if (out_word.heading_angle !== x.heading_angle) begin
            $error("heading_angle exp %h got %h", x.heading_angle,
                   out_word.heading_angle);
            n_errors++;
          end
          if (out_word.linear_speed !== x.linear_speed) begin
            $error("linear_speed exp %h got %h", x.linear_speed,
                   out_word.linear_speed);
            n_errors++;
          end
          if (out_word.angular_speed !== x.angular_speed) begin
            $error("angular_speed exp %h got %h", x.angular_speed,
                   out_word.angular_speed);
            n_errors++;
          end
          if (out_word.speed_valid !== x.speed_valid) begin
            $error("speed_valid exp %b got %b", x.speed_valid, out_word.speed_valid);
            n_errors++;
          end
        end
      end
      // Stall is free to change each cycle; a long hold-off fills the queue.
      if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else if (drain_mode) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(99) < 25);
      end
    end
  end

  task automatic write_reg(logic [odo_pkg::CFG_INDEX_BITS-1:0] idx, logic [31:0] val);
    @(posedge clk);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    // Mirror the write in the predictor; unknown indices are dropped.
    if (idx == odo_pkg::REG_DISTANCE_PER_COUNT) mdl_dpc = val;
    else if (idx == odo_pkg::REG_INV_TRACK_WIDTH) mdl_itw = val[23:0];
  endtask

  // Block until every queued word has gone in and come back, then settle.
  task automatic drain();
    drain_mode = 1'b1;
    wait (pending_words.size() == 0 && !in_valid && odo_expected.size() == 0);
    repeat (80) @(posedge clk);
    drain_mode = 1'b0;
  endtask

  function automatic odo_pkg::in_word_t rand_word(logic [31:0] pl, logic [31:0] pr);
    odo_pkg::in_word_t w;
    int k;
    k = $urandom_range(9);
    if (k < 7) begin
      // Well-behaved motion: small count steps from the last sample.
      w.left_count = pl + 32'($signed($urandom_range(4000)) - 2000);
      w.right_count = pr + 32'($signed($urandom_range(4000)) - 2000);
    end else begin
      w.left_count = $urandom;
      w.right_count = $urandom;
    end
    w.elapsed_us = ($urandom_range(9) == 0) ? 24'd0 :
                   ($urandom_range(3) == 0) ? 24'($urandom) : 24'($urandom_range(200000, 1));
    return w;
  endfunction

  task automatic push_words(int n);
    logic [31:0] pl, pr;
    odo_pkg::in_word_t w;
    pl = 0; pr = 0;
    for (int i = 0; i < n; i++) begin
      w = rand_word(pl, pr);
      pl = w.left_count; pr = w.right_count;
      pending_words.push_back(w);
    end
  endtask

  initial begin
    mdl_dpc = odo_pkg::RESET_DISTANCE_PER_COUNT;
    mdl_itw = odo_pkg::RESET_INV_TRACK_WIDTH;
    {mdl_prev_l, mdl_prev_r, mdl_x, mdl_y, mdl_hdg} = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed: first sample from zero, zero time, extremes, counter wrap.
    pending_words.push_back('{32'sd100, 32'sd300, 24'd50000});
    pending_words.push_back('{32'sd100, 32'sd300, 24'd0});
    pending_words.push_back('{32'sd400, 32'sd10, 24'd1});
    pending_words.push_back('{32'h7fff_ffff, 32'h8000_0000, 24'd1});
    pending_words.push_back('{32'h8000_0000, 32'h7fff_ffff, 24'hff_ffff});
    pending_words.push_back('{32'hffff_fff0, 32'h0000_0010, 24'd20});
    pending_words.push_back('{32'h0000_0010, 32'hffff_fff0, 24'd0});
    pending_words.push_back('{32'sd0, 32'sd0, 24'd1000});
    pending_words.push_back('{32'sd50000, 32'sd50000, 24'd10});
    pending_words.push_back('{-32'sd50000, -32'sd50000, 24'd10});
    drain();

    write_reg(odo_pkg::REG_DISTANCE_PER_COUNT, 32'hffff_ffff);
    write_reg(odo_pkg::REG_INV_TRACK_WIDTH, 32'h00ff_ffff);
    write_reg(8'd2, 32'h1234_5678);
    write_reg(8'hff, 32'hffff_ffff);
    pending_words.push_back('{32'h7fff_ffff, 32'h8000_0001, 24'd1});
    pending_words.push_back('{32'sd0, 32'sd0, 24'd1});
    pending_words.push_back('{32'sd7, 32'sd12345, 24'd3});
    drain();

    write_reg(odo_pkg::REG_DISTANCE_PER_COUNT, 32'd0);
    write_reg(odo_pkg::REG_INV_TRACK_WIDTH, 32'd0);
    pending_words.push_back('{32'sd999, 32'sd5, 24'd7});
    drain();

    // Random phases under several settings; the first holds off the output.
    write_reg(odo_pkg::REG_DISTANCE_PER_COUNT, odo_pkg::RESET_DISTANCE_PER_COUNT);
    write_reg(odo_pkg::REG_INV_TRACK_WIDTH, {8'd0, odo_pkg::RESET_INV_TRACK_WIDTH});
    push_words(500);
    hold_left = 2000;
    drain();
    write_reg(odo_pkg::REG_DISTANCE_PER_COUNT, $urandom);
    write_reg(odo_pkg::REG_INV_TRACK_WIDTH, $urandom_range(24'hff_ffff));
    push_words(500);
    drain();
    write_reg(odo_pkg::REG_DISTANCE_PER_COUNT, $urandom_range(2000000));
    write_reg(odo_pkg::REG_INV_TRACK_WIDTH, $urandom_range(400000));
    push_words(500);
    drain();

    if (n_errors == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

  // Generous timeout far beyond the slowest correct run.
  initial begin
    #20ms;
    $display("testbench failed");
    $finish;
  end

endmodule

>>> diff_drive_odometry_unit.f
rtl/odo_pkg.sv
rtl/odo_front.sv
rtl/odo_queue.sv
rtl/odo_div.sv
rtl/odo_back.sv
rtl/diff_drive_odometry_unit.sv
tb/testbench.sv
